>>> hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define LVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define LVR_ASSERT_NEVER(lbl, cond, msg) \
  `LVR_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/lvr_pkg.sv
package lvr_pkg;

  localparam int VOL_W  = 16;
  localparam int TIME_W = 32;
  localparam int DUR_W  = 16;
  localparam int PROD_W = VOL_W + DUR_W;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 2;

  localparam logic [VOL_W-1:0] UNITY_VOL = 16'd32768;

  // operation codes
  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_START_VOL  = 2'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_VOL = 2'd1;
  localparam logic [IDX_W-1:0] REG_DURATION   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WAITD,
    ST_DONE
  } lvr_state_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DUR_W-1:0]  divisor;
  } lvr_div_req_t;

  typedef struct packed {
    logic             done;
    logic [VOL_W-1:0] quotient;
  } lvr_div_rsp_t;

  // clamp a volume to unity
  function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] v);
    sat_vol = (v > UNITY_VOL) ? UNITY_VOL : v;
  endfunction

endpackage

>>> hdl/linear_volume_ramp_unit.sv
// Linear volume ramp. Three registers set the ramp: start volume, target
// volume (both Q1.15, 32768 is unity, larger values are clamped to unity)
// and duration in ms (zero counts as one). A start beat arms the ramp; the
// first query after it takes its now_ms as the ramp origin, and each query
// returns start + (target - start) * min(elapsed, duration) / duration with
// the step truncated towards the start volume, elapsed counted modulo 2^32.
// The ramp drops out at the first query whose elapsed exceeds the duration.
// A terminate beat stops it; while stopped, the last volume is returned
// (unity after reset). Every input beat yields exactly one result beat.
// Start, terminate, and queries with no ramp running are answered straight
// from the idle state. A query on a running ramp goes through a multiply
// state for the 16x16 product, then the restoring divider that produces one
// quotient bit per cycle, then a done state that offers the result. The input
// is not ready while a query is in flight or while a result waits to be
// taken. Registers are sampled when the query is accepted.
module linear_volume_ramp_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [lvr_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lvr_pkg::VOL_W-1:0]   cfg_wdata,
  // input beats
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lvr_pkg::OP_W-1:0]    in_operation,
  input  logic [lvr_pkg::TIME_W-1:0]  in_now_ms,
  // result beats
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lvr_pkg::VOL_W-1:0]   out_volume,
  output logic                        out_ramp_active
);
  import lvr_pkg::*;
  `include "assert_macros.svh"

  // configuration registers
  logic [VOL_W-1:0]  start_vol_r;
  logic [VOL_W-1:0]  target_vol_r;
  logic [DUR_W-1:0]  dur_r;

  // ramp state
  lvr_state_t        state_r, state_nxt;
  logic              running_r, running_nxt;
  logic              latched_r, latched_nxt;
  logic [TIME_W-1:0] origin_r, origin_nxt;
  logic [VOL_W-1:0]  held_r, held_nxt;

  // per query operands
  logic [VOL_W-1:0]  s_r, s_nxt;
  logic [VOL_W-1:0]  diff_r, diff_nxt;
  logic              up_r, up_nxt;
  logic [DUR_W-1:0]  d_r, d_nxt;
  logic [DUR_W-1:0]  e_r, e_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [VOL_W-1:0]  out_volume_r, out_volume_nxt;
  logic              out_active_r, out_active_nxt;

  // combinational helpers
  logic              accept;
  logic [VOL_W-1:0]  s_sat, t_sat;
  logic [DUR_W-1:0]  d_eff;
  logic [TIME_W-1:0] origin_eff;
  logic [TIME_W-1:0] elapsed;
  logic              overrun;

  lvr_div_req_t      div_req;
  lvr_div_rsp_t      div_rsp;

  lvr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // operand preparation at acceptance
  assign s_sat      = sat_vol(start_vol_r);
  assign t_sat      = sat_vol(target_vol_r);
  assign d_eff      = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign origin_eff = latched_r ? origin_r : in_now_ms;
  assign elapsed    = in_now_ms - origin_eff;
  assign overrun    = elapsed > TIME_W'(d_eff);

  always_comb begin
    div_req.start    = (state_r == ST_DIV);
    div_req.dividend = prod_r;
    div_req.divisor  = d_r;
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    latched_nxt    = latched_r;
    origin_nxt     = origin_r;
    held_nxt       = held_r;
    s_nxt          = s_r;
    diff_nxt       = diff_r;
    up_nxt         = up_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_volume_nxt = out_volume_r;
    out_active_nxt = out_active_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_operation == OP_START) begin
            running_nxt    = 1'b1;
            latched_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_volume_nxt = held_r;
            out_active_nxt = 1'b1;
          end else if (in_operation == OP_QUERY && running_r) begin
            // origin latched on the first query of the ramp
            latched_nxt = 1'b1;
            origin_nxt  = origin_eff;
            s_nxt       = s_sat;
            up_nxt      = t_sat >= s_sat;
            diff_nxt    = (t_sat >= s_sat) ? t_sat - s_sat : s_sat - t_sat;
            d_nxt       = d_eff;
            e_nxt       = overrun ? d_eff : elapsed[DUR_W-1:0];
            running_nxt = !overrun;
            state_nxt   = ST_MUL;
          end else if (in_operation == OP_STOP) begin
            running_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_volume_nxt = held_r;
            out_active_nxt = 1'b0;
          end else begin
            // query with no ramp, or unused code: hold everything
            out_valid_nxt  = 1'b1;
            out_volume_nxt = held_r;
            out_active_nxt = running_r;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(diff_r) * PROD_W'(e_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_WAITD;
      end
      ST_WAITD: begin
        if (div_rsp.done) begin
          held_nxt  = up_r ? s_r + div_rsp.quotient : s_r - div_rsp.quotient;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_volume_nxt = held_r;
          out_active_nxt = running_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_vol_r  <= UNITY_VOL;
      target_vol_r <= UNITY_VOL;
      dur_r        <= DUR_W'(1);
      running_r    <= 1'b0;
      latched_r    <= 1'b0;
      origin_r     <= '0;
      held_r       <= UNITY_VOL;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_VOL:  start_vol_r  <= cfg_wdata;
          REG_TARGET_VOL: target_vol_r <= cfg_wdata;
          REG_DURATION:   dur_r        <= cfg_wdata;
          default: ;
        endcase
      end
      running_r   <= running_nxt;
      latched_r   <= latched_nxt;
      origin_r    <= origin_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    diff_r       <= diff_nxt;
    up_r         <= up_nxt;
    d_r          <= d_nxt;
    e_r          <= e_nxt;
    prod_r       <= prod_nxt;
    out_volume_r <= out_volume_nxt;
    out_active_r <= out_active_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_volume      = out_volume_r;
  assign out_ramp_active = out_active_r;

  // a start beat re-arms the ramp and forgets the old origin
  `LVR_ASSERT(a_start_arms, (accept && in_operation == OP_START) |=> (running_r && !latched_r), "start beat did not arm the ramp")
  // the step never exceeds the volume span
  `LVR_ASSERT(a_quot_bound, div_rsp.done |-> (div_rsp.quotient <= diff_r), "ramp step beyond volume span")
  // divider results only arrive while the sequencer waits for them
  `LVR_ASSERT(a_done_waiting, div_rsp.done |-> (state_r == ST_WAITD), "divider finished outside wait state")
  // held volume stays within unity
  `LVR_ASSERT_NEVER(a_held_range, held_r > UNITY_VOL, "held volume above unity")

endmodule

>>> hdl/lvr_div.sv
module lvr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lvr_pkg::lvr_div_req_t req,
  output lvr_pkg::lvr_div_rsp_t rsp
);
  import lvr_pkg::*;

  // quotient is known to fit in VOL_W bits, so one step per quotient bit
  localparam int STEPS = VOL_W;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DUR_W-1:0] rem_r;
  logic [DUR_W-1:0] lo_r;
  logic [DUR_W-1:0] dsr_r;
  logic [VOL_W-1:0] q_r;
  logic [DUR_W+1:0] trial;
  logic             fits;

  // one restoring subtract per cycle
  assign trial = {1'b0, rem_r, lo_r[DUR_W-1]} - {2'b00, dsr_r};
  assign fits  = !trial[DUR_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[PROD_W-1:DUR_W];
      lo_r  <= req.dividend[DUR_W-1:0];
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DUR_W-1:0] : {rem_r[DUR_W-2:0], lo_r[DUR_W-1]};
      lo_r  <= {lo_r[DUR_W-2:0], 1'b0};
      q_r   <= {q_r[VOL_W-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

>>> sim/linear_volume_ramp_unit_test.sv
module linear_volume_ramp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lvr_pkg::*;

  // operation code with no meaning: the block must leave its state alone
  localparam logic [OP_W-1:0]  OP_RESERVED = 2'd3;
  // register index with nothing behind it
  localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;

  // cycles to let the block settle before a register write, and at the end
  localparam int SETTLE_CYCLES = 25;
  localparam int TAIL_CYCLES   = 40;
  // hard stop for a hung run
  localparam int CYCLE_LIMIT   = 400000;
  // mismatches beyond this many are only counted
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] now;
  } ramp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VOL_W-1:0] volume;
    logic             active;
  } gain_check_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // block inputs, all at known values from time zero
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [VOL_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = OP_QUERY;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VOL_W-1:0]  out_volume;
  logic              out_ramp_active;

  linear_volume_ramp_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_volume      (out_volume),
    .out_ramp_active (out_ramp_active)
  );

  // beats waiting to be driven, and results the block still owes us
  ramp_cmd_t   pending_cmds[$];
  gain_check_t expected_gains[$];

  // idle percentages of the two sides, changed between phases
  int send_idle_pct = 25;
  int recv_idle_pct = 70;

  int mismatch_count = 0;
  int cycle_count = 0;

  // shadow of the registers as the block should hold them
  logic [VOL_W-1:0] reg_start  = UNITY_VOL;
  logic [VOL_W-1:0] reg_target = UNITY_VOL;
  logic [DUR_W-1:0] reg_span   = 16'd1;

  // shadow of the ramp state
  logic              ramp_on    = 1'b0;
  logic              anchor_set = 1'b0;
  logic [TIME_W-1:0] anchor_ms  = '0;
  logic [VOL_W-1:0]  last_gain  = UNITY_VOL;

  // works out the result of one input beat and moves the shadow state on
  function automatic gain_check_t predict_gain(input ramp_cmd_t cmd);
    logic [VOL_W-1:0]  s_vol;
    logic [VOL_W-1:0]  t_vol;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] used;
    logic [47:0]       vol_gap;
    logic [47:0]       step;
    gain_check_t       res;
    case (cmd.op)
      OP_START: begin
        ramp_on = 1'b1;
        anchor_set = 1'b0;
      end
      OP_QUERY: begin
        if (ramp_on) begin
          // first query after a start fixes the origin
          if (!anchor_set) begin
            anchor_ms = cmd.now;
            anchor_set = 1'b1;
          end
          // volumes above unity clamp, zero duration counts as one ms
          s_vol = (reg_start > UNITY_VOL) ? UNITY_VOL : reg_start;
          t_vol = (reg_target > UNITY_VOL) ? UNITY_VOL : reg_target;
          span = (reg_span == '0) ? 32'd1 : {16'd0, reg_span};
          // elapsed wraps modulo 2^32, so never negative
          elapsed = cmd.now - anchor_ms;
          if (elapsed > span) begin
            used = span;
            ramp_on = 1'b0;
          end else begin
            used = elapsed;
          end
          vol_gap = (t_vol >= s_vol) ? t_vol - s_vol : s_vol - t_vol;
          step = (vol_gap * used) / span;
          if (t_vol >= s_vol) begin
            last_gain = s_vol + step[VOL_W-1:0];
          end else begin
            last_gain = s_vol - step[VOL_W-1:0];
          end
        end
      end
      OP_STOP: begin
        ramp_on = 1'b0;
      end
      default: begin
      end
    endcase
    res.op = cmd.op;
    res.volume = last_gain;
    res.active = ramp_on;
    return res;
  endfunction

  // driver: next pending beat goes out once the slot is free
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_operation <= pending_cmds[0].op;
        in_now_ms <= pending_cmds[0].now;
        pending_cmds.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  gain_check_t want;

  // monitor: checks each result beat, then records what an accepted input beat owes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_gains.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("unexpected result beat: volume %0d active %0d",
                     out_volume, out_ramp_active);
          end
        end else begin
          want = expected_gains.pop_front();
          if (out_volume !== want.volume || out_ramp_active !== want.active) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("mismatch on op %0d: expected volume %0d active %0d, %s %0d active %0d",
                       want.op, want.volume, want.active, "got volume",
                       out_volume, out_ramp_active);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_gains.push_back(predict_gain('{op: in_operation, now: in_now_ms}));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linear_volume_ramp_unit test failed");
      $finish;
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now);
    pending_cmds.push_back('{op: op, now: now});
  endtask

  // wait until every beat is out and every result is back, then a little longer
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_cmds.size() != 0 || in_valid || expected_gains.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write per edge, shadow copy updated alongside
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VOL_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_START_VOL:  reg_start = val;
      REG_TARGET_VOL: reg_target = val;
      REG_DURATION:   reg_span = val;
      default: begin
      end
    endcase
  endtask

  // reprogram the ramp only once the block has gone quiet
  task automatic apply_settings(input logic [VOL_W-1:0] s_vol, input logic [VOL_W-1:0] t_vol,
                                input logic [DUR_W-1:0] span);
    wait_drained();
    write_reg(REG_START_VOL, s_vol);
    write_reg(REG_TARGET_VOL, t_vol);
    write_reg(REG_DURATION, span);
    // now and then poke the empty index; it must change nothing
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_UNUSED, VOL_W'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [VOL_W-1:0] rand_vol();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return UNITY_VOL;
      2: return VOL_W'($urandom);     // may exceed unity
      default: return VOL_W'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] rand_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'hFFFF;
      2: return DUR_W'($urandom);
      3: return 16'd1;
      default: return DUR_W'($urandom_range(1, 64));
    endcase
  endfunction

  // a start followed by queries walking along the ramp, past its end now and then
  task automatic queue_ramp_run(ref int count);
    logic [TIME_W-1:0] origin;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] span;
    int                n;
    origin = $urandom;
    offset = '0;
    span = (reg_span == '0) ? 32'd1 : {16'd0, reg_span};
    n = $urandom_range(2, 8);
    push_cmd(OP_START, $urandom);
    count++;
    for (int i = 0; i < n; i++) begin
      push_cmd(OP_QUERY, origin + offset);
      count++;
      case ($urandom_range(0, 11))
        0: offset = span;                // lands exactly on the end
        1: offset = span + 1;            // just past the end
        2: offset = $urandom;            // wild jump, may wrap
        3: begin
          push_cmd(OP_RESERVED, $urandom);
          count++;
        end
        default: offset = offset + $urandom_range(0, span / 3 + 1);
      endcase
    end
    case ($urandom_range(0, 5))
      0: begin
        push_cmd(OP_STOP, $urandom);
        push_cmd(OP_QUERY, origin + offset);
        count += 2;
      end
      1: begin
        // restart, running or not: the origin is taken afresh
        push_cmd(OP_START, $urandom);
        push_cmd(OP_QUERY, origin + offset + 7);
        count += 2;
      end
      default: begin
      end
    endcase
  endtask

  // one batch of random beats under one random setting
  task automatic random_batch(input int size);
    int count;
    count = 0;
    apply_settings(rand_vol(), rand_vol(), rand_span());
    while (count < size) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_ramp_run(count);
      end else begin
        // noise: anything at any time
        push_cmd(OP_W'($urandom_range(0, 3)), $urandom);
        count++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset: unity held, nothing running, reserved op and stop harmless
    push_cmd(OP_QUERY, 32'd0);
    push_cmd(OP_RESERVED, 32'hFFFF_FFFF);
    push_cmd(OP_STOP, 32'd0);

    // rising ramp over four ms, through the exact end and one past it
    apply_settings(16'd0, UNITY_VOL, 16'd4);
    push_cmd(OP_START, 32'd0);
    push_cmd(OP_QUERY, 32'd100);
    push_cmd(OP_QUERY, 32'd101);
    push_cmd(OP_QUERY, 32'd104);
    push_cmd(OP_QUERY, 32'd105);
    push_cmd(OP_QUERY, 32'd106);

    // falling ramp, start above unity clamps, zero duration acts as one,
    // elapsed wraps through zero
    apply_settings(16'hFFFF, 16'd0, 16'd0);
    push_cmd(OP_START, 32'h1234_5678);
    push_cmd(OP_QUERY, 32'hFFFF_FFFF);
    push_cmd(OP_QUERY, 32'd0);
    push_cmd(OP_RESERVED, 32'd0);
    push_cmd(OP_STOP, 32'hFFFF_FFFF);
    push_cmd(OP_QUERY, 32'd1);

    // longest duration, target above unity, restart mid-ramp,
    // then a backwards time that wraps far past the end
    apply_settings(16'd100, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_START, 32'd0);
    push_cmd(OP_QUERY, 32'd0);
    push_cmd(OP_QUERY, 32'd1);
    push_cmd(OP_QUERY, 32'd30000);
    push_cmd(OP_START, 32'd0);
    push_cmd(OP_QUERY, 32'd5);
    push_cmd(OP_QUERY, 32'd0);
    push_cmd(OP_QUERY, 32'd9);

    // random part, first with slow sender and slower receiver
    repeat (4) random_batch(50);

    wait_drained();
    send_idle_pct = 70;
    recv_idle_pct = 25;
    repeat (4) random_batch(50);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) random_batch(50);

    // all beats out, all results back, then a quiet tail for stray beats
    do begin
      @(posedge clk);
    end while (pending_cmds.size() != 0 || in_valid || expected_gains.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_gains.size() == 0) begin
      $display("linear_volume_ramp_unit test passed");
    end else begin
      $display("linear_volume_ramp_unit test failed");
    end
    $finish;
  end

endmodule
